>>> hdl/swpm_pkg.sv
// Package for the sliding window pattern matcher.
// Holds default sizes, field widths, item kind codes and the cell control struct.
// No dependencies.
package swpm_pkg;

	localparam int MAX_PATTERN_DEF  = 32;
	localparam int ELEMENT_BITS_DEF = 16;
	localparam int PLEN_W           = 6;
	localparam int PIDX_W           = 5;

	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	typedef struct packed {
		logic shift;
		logic rot_up;
		logic rot_dn;
	} cell_ctrl_t;

endpackage

>>> hdl/swpm_if.sv
// Channel interfaces of the sliding window pattern matcher: input items and results.
// Depends on swpm_pkg for field widths.
interface swpm_in_if #(
	parameter int ELEMENT_BITS = swpm_pkg::ELEMENT_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [ELEMENT_BITS-1:0]         element;
	logic [swpm_pkg::PIDX_W-1:0]     pattern_index;
	logic                            first_of_text;
	logic                            last_of_text;

	modport source (
		output valid, kind, element, pattern_index, first_of_text, last_of_text,
		input  ready
	);
	modport sink (
		input  valid, kind, element, pattern_index, first_of_text, last_of_text,
		output ready
	);
endinterface

interface swpm_out_if;
	logic valid;
	logic ready;
	logic match_here;
	logic found;
	logic is_final;

	modport source (
		output valid, match_here, found, is_final,
		input  ready
	);
	modport sink (
		input  valid, match_here, found, is_final,
		output ready
	);
endinterface

>>> hdl/swpm_cell.sv
// One cell of the matcher chain: a text window slot and a pattern slot with its comparator.
// Depends on swpm_pkg for the cell control struct.
module swpm_cell #(
	parameter int ELEMENT_BITS = swpm_pkg::ELEMENT_BITS_DEF
) (
	input  logic                       clk,
	input  swpm_pkg::cell_ctrl_t       ctrl,
	input  logic                       active,
	input  logic                       load_en,
	input  logic [ELEMENT_BITS-1:0]    load_data,
	input  logic [ELEMENT_BITS-1:0]    win_prev,
	input  logic [ELEMENT_BITS-1:0]    pat_lo,
	input  logic [ELEMENT_BITS-1:0]    pat_hi,
	output logic [ELEMENT_BITS-1:0]    win_q,
	output logic [ELEMENT_BITS-1:0]    pat_q,
	output logic                       ok
);
	import swpm_pkg::*;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			win_q <= win_prev;
		end
	end

	always_ff @(posedge clk) begin
		priority if (load_en) begin
			pat_q <= load_data;
		end else if (ctrl.rot_up) begin
			pat_q <= pat_lo;
		end else if (ctrl.rot_dn) begin
			pat_q <= pat_hi;
		end else begin
			pat_q <= pat_q;
		end
	end

	assign ok = !active || (win_q == pat_q);

endmodule

>>> hdl/sliding_window_pattern_match_core.sv
// Sliding window pattern matcher. Pattern elements are loaded by index, then text elements
// stream through a chain of cells that compares the whole window with the pattern at once.
// The result of a text element passes the stage register valid_s1 and the output register
// before it is offered, and a new element can transfer while earlier ones are in flight unless
// the output stalls; pattern loads give no result. Every cell keeps its pattern slot aligned to
// the current length, so after a length write the chain rotates one place per cycle once no
// text element is in valid_s1, with input ready held low, until it has rotated as many places
// as the length changed (at most MAX_PATTERN - 1). Depends on swpm_pkg, swpm_if and swpm_cell.
module sliding_window_pattern_match_core #(
	parameter int MAX_PATTERN  = swpm_pkg::MAX_PATTERN_DEF,
	parameter int ELEMENT_BITS = swpm_pkg::ELEMENT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	swpm_in_if.sink                       items,
	swpm_out_if.source                    results,
	input  logic                          cfg_we,
	input  logic [swpm_pkg::PLEN_W-1:0]   cfg_wdata
);
	import swpm_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [LW-1:0]           mt_q;
	logic [LW-1:0]           ma_q;
	logic [LW-1:0]           seen_q;
	logic                    found_q;
	logic                    valid_s1;
	logic                    first_s1;
	logic                    last_s1;
	logic                    out_valid_q;
	logic                    match_q;
	logic                    found_out_q;
	logic                    final_q;

	logic                    aligned;
	logic                    adv;
	logic                    acc;
	logic                    text_acc;
	logic                    hit;
	logic                    found_new;
	logic [LW-1:0]           len_eff;
	cell_ctrl_t              ctrl;
	logic [MAX_PATTERN-1:0]  load_en;
	logic [MAX_PATTERN-1:0]  active;
	logic [MAX_PATTERN-1:0]  ok;
	logic [ELEMENT_BITS-1:0] win [MAX_PATTERN];
	logic [ELEMENT_BITS-1:0] pat [MAX_PATTERN];

	assign aligned      = (ma_q == mt_q);
	assign adv          = !out_valid_q || results.ready;
	assign items.ready  = aligned && (!valid_s1 || adv);
	assign acc          = items.valid && items.ready;
	assign text_acc     = acc && (items.kind == KIND_TEXT);

	assign ctrl.shift   = text_acc;
	assign ctrl.rot_up  = !aligned && !valid_s1 && (mt_q > ma_q);
	assign ctrl.rot_dn  = !aligned && !valid_s1 && (mt_q < ma_q);

	always_comb begin
		if (cfg_wdata == '0) begin
			len_eff = LW'(1);
		end else if (int'(cfg_wdata) > MAX_PATTERN) begin
			len_eff = LW'(MAX_PATTERN);
		end else begin
			len_eff = LW'(cfg_wdata);
		end
	end

	always_comb begin
		int d;
		d = int'(ma_q) - 1 - int'(items.pattern_index);
		if (d < 0) begin
			d = d + MAX_PATTERN;
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			load_en[i] = acc && (items.kind == KIND_PATTERN)
				&& (int'(items.pattern_index) < MAX_PATTERN) && (d == i);
			active[i]  = i < int'(ma_q);
		end
	end

	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		swpm_cell #(
			.ELEMENT_BITS(ELEMENT_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.active   (active[g]),
			.load_en  (load_en[g]),
			.load_data(items.element),
			.win_prev ((g == 0) ? items.element : win[(g + MAX_PATTERN - 1) % MAX_PATTERN]),
			.pat_lo   (pat[(g + MAX_PATTERN - 1) % MAX_PATTERN]),
			.pat_hi   (pat[(g + 1) % MAX_PATTERN]),
			.win_q    (win[g]),
			.pat_q    (pat[g]),
			.ok       (ok[g])
		);
	end

	assign hit       = (seen_q >= ma_q) && (&ok);
	assign found_new = (first_s1 ? 1'b0 : found_q) | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_q <= LW'(1);
			ma_q <= LW'(1);
		end else begin
			if (cfg_we) begin
				mt_q <= len_eff;
			end
			if (ctrl.rot_up) begin
				ma_q <= ma_q + LW'(1);
			end else if (ctrl.rot_dn) begin
				ma_q <= ma_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (text_acc) begin
			if (items.first_of_text) begin
				seen_q <= LW'(1);
			end else if (seen_q != LW'(MAX_PATTERN)) begin
				seen_q <= seen_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= text_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc) begin
			first_s1 <= items.first_of_text;
			last_s1  <= items.last_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				found_q <= found_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			match_q     <= hit;
			found_out_q <= found_new;
			final_q     <= last_s1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.match_here = match_q;
	assign results.found      = found_out_q;
	assign results.is_final   = final_q;

	a_accept_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> aligned)
		else $error("Item transferred while the pattern cells were being rotated.");

	a_match_implies_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && match_q) |-> found_out_q)
		else $error("Match reported without the sticky verdict.");

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(seen_q) <= MAX_PATTERN)
		else $error("Seen count went past the window depth.");

	a_rotate_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.rot_up || ctrl.rot_dn) |-> (!valid_s1 && !acc))
		else $error("Pattern rotation overlapped a text element in flight.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(seen_q) && $stable(found_q)))
		else $error("Stalled stage lost its item or state.");

endmodule

>>> tb/sv/swpm_match_check.sv
// Checker for the sliding window pattern matcher: watches both channels and the length register.
// Predicts each text verdict from its own pattern and window copies and compares it on transfer.
// Depends on swpm_pkg and the channel interfaces in swpm_if.
module swpm_match_check (
	input  logic                        clk,
	input  logic                        arst_n,
	swpm_in_if                          items,
	swpm_out_if                         results,
	input  logic                        cfg_we,
	input  logic [swpm_pkg::PLEN_W-1:0] cfg_wdata,
	output int                          mismatches,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import swpm_pkg::*;

	localparam int DEPTH = MAX_PATTERN_DEF;
	localparam int EW    = ELEMENT_BITS_DEF;

	typedef struct packed {
		logic match_here;
		logic found;
		logic is_final;
	} verdict_t;

	logic [EW-1:0]     pattern_mem [DEPTH];
	logic [EW-1:0]     recent [DEPTH];
	int                elems_seen;
	logic              found_so_far;
	logic [PLEN_W-1:0] length_reg;
	verdict_t          verdict_q [$];
	verdict_t          want;
	verdict_t          got;

	function automatic int used_length();
		int m;
		m = length_reg;
		if (m == 0) m = 1;
		if (m > DEPTH) m = DEPTH;
		return m;
	endfunction

	function automatic verdict_t shift_and_compare(input logic [EW-1:0] elem,
			input logic first, input logic last);
		verdict_t v;
		int       m;
		int       j;
		logic     hit;
		if (first) begin
			for (j = 0; j < DEPTH; j++) recent[j] = '0;
			elems_seen   = 0;
			found_so_far = 1'b0;
		end
		for (j = DEPTH - 1; j > 0; j--) recent[j] = recent[j-1];
		recent[0] = elem;
		if (elems_seen < DEPTH) elems_seen++;
		m   = used_length();
		hit = (elems_seen >= m);
		for (j = 0; j < m; j++) begin
			if (pattern_mem[j] != recent[m-1-j]) hit = 1'b0;
		end
		if (hit) found_so_far = 1'b1;
		v.match_here = hit;
		v.found      = found_so_far;
		v.is_final   = last;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEPTH; j++) recent[j] = '0;
			elems_seen   = 0;
			found_so_far = 1'b0;
			length_reg   = 1;
			verdict_q.delete();
			mismatches   = 0;
			pending      = 0;
		end else begin
			if (cfg_we === 1'b1) length_reg = cfg_wdata;
			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				got = '{results.match_here, results.found, results.is_final};
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with no verdict outstanding: %b%b%b",
							$realtime, got.match_here, got.found, got.is_final);
				end else begin
					want = verdict_q.pop_front();
					if (got.match_here !== want.match_here || got.found !== want.found ||
							got.is_final !== want.is_final) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: verdict mismatch, expected %b%b%b, actual %b%b%b",
								$realtime, want.match_here, want.found, want.is_final,
								got.match_here, got.found, got.is_final);
					end
				end
			end
			if (items.valid === 1'b1 && items.ready === 1'b1) begin
				if (items.kind == KIND_PATTERN)
					pattern_mem[items.pattern_index] = items.element;
				else
					verdict_q.insert(verdict_q.size(), shift_and_compare(items.element,
						items.first_of_text, items.last_of_text));
			end
			pending = verdict_q.size();
		end
	end

endmodule

>>> tb/sv/sliding_window_pattern_match_core_tb.sv
// Top of the testbench for the sliding window pattern matcher: clock, reset and stimulus.
// Runs directed searches, then random phases of length setting, pattern loads and texts.
// Depends on swpm_pkg, swpm_if, swpm_match_check and the core.
module sliding_window_pattern_match_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swpm_pkg::*;

	localparam int DEPTH       = MAX_PATTERN_DEF;
	localparam int EW          = ELEMENT_BITS_DEF;
	localparam int HOLD_CYCLES = 200;
	localparam int RAND_ITEMS  = 1250;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [PLEN_W-1:0] cfg_wdata;
	int                mismatches;
	int                pending;

	int                burst_left;
	int                item_count;
	int                active_len;
	int                hold_asks;
	logic [EW-1:0]     pat_val [DEPTH];
	logic [EW-1:0]     alphabet [$];

	swpm_in_if  item_ch ();
	swpm_out_if result_ch ();

	sliding_window_pattern_match_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	swpm_match_check u_match_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (item_ch),
		.results    (result_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("** sliding_window_pattern_match_core: FAILED **");
		$finish;
	end

	initial begin
		int pct;
		int span_left;
		int seen_asks;
		result_ch.ready = 1'b0;
		pct       = 100;
		span_left = 0;
		seen_asks = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_asks != seen_asks) begin
				seen_asks       = hold_asks;
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (span_left == 0) begin
				span_left = $urandom_range(8, 80);
				case ($urandom_range(3))
					0: begin
						pct = 100;
					end
					1: begin
						pct = 70;
					end
					2: begin
						pct = 35;
					end
					default: begin
						pct = 10;
					end
				endcase
			end
			span_left--;
			result_ch.ready = ($urandom_range(99) < pct);
		end
	end

	task automatic put_item(input logic k, input logic [EW-1:0] e,
			input logic [PIDX_W-1:0] ix, input logic f, input logic l);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(3) != 0) gap = $urandom_range(1, 6);
		end
		burst_left--;
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid         = 1'b0;
			item_ch.kind          = 1'($urandom);
			item_ch.element       = EW'($urandom);
			item_ch.pattern_index = PIDX_W'($urandom);
		end
		@(negedge clk);
		item_ch.valid         = 1'b1;
		item_ch.kind          = k;
		item_ch.element       = e;
		item_ch.pattern_index = ix;
		item_ch.first_of_text = f;
		item_ch.last_of_text  = l;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		item_count++;
	endtask

	task automatic load_slot(input int ix, input logic [EW-1:0] v);
		put_item(KIND_PATTERN, v, PIDX_W'(ix), 1'($urandom), 1'($urandom));
		pat_val[ix] = v;
	endtask

	task automatic put_text(input logic [EW-1:0] e, input logic f, input logic l);
		put_item(KIND_TEXT, e, PIDX_W'($urandom), f, l);
	endtask

	task automatic drain();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_length(input logic [PLEN_W-1:0] v);
		drain();
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		active_len = (v == 0) ? 1 : (v > DEPTH) ? DEPTH : v;
	endtask

	function automatic logic [EW-1:0] text_elem();
		case ($urandom_range(3))
			0, 1: begin
				return alphabet[$urandom_range(alphabet.size() - 1)];
			end
			2: begin
				return pat_val[$urandom_range(active_len - 1)];
			end
			default: begin
				return EW'($urandom);
			end
		endcase
	endfunction

	task automatic send_text(input int n);
		logic [EW-1:0] body [$];
		int            k;
		int            pos;
		logic          fm;
		logic          lm;
		while (body.size() < n) begin
			if ($urandom_range(3) == 0) begin
				for (k = 0; k < active_len; k++) body.insert(body.size(), pat_val[k]);
				if ($urandom_range(3) == 0) begin
					pos       = body.size() - 1 - $urandom_range(active_len - 1);
					body[pos] = body[pos] ^ (EW'(1) << $urandom_range(EW - 1));
				end
			end else begin
				body.insert(body.size(), text_elem());
			end
		end
		for (k = 0; k < body.size(); k++) begin
			if ($urandom_range(49) == 0) load_slot($urandom_range(DEPTH - 1), text_elem());
			fm = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
			lm = (k == body.size() - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
			put_text(body[k], fm, lm);
		end
	endtask

	task automatic run_phase(input int phase_no);
		logic [PLEN_W-1:0] lv;
		logic [PLEN_W-1:0] extremes [6];
		int                k;
		int                r;
		extremes = '{0, 1, 31, 32, 33, 63};
		r = $urandom_range(9);
		if (phase_no == 0)
			lv = 32;
		else if (phase_no == 1)
			lv = 63;
		else if (r == 0)
			lv = extremes[$urandom_range(5)];
		else if (r <= 6)
			lv = PLEN_W'($urandom_range(1, 4));
		else if (r <= 8)
			lv = PLEN_W'($urandom_range(5, 12));
		else
			lv = PLEN_W'($urandom_range(13, 32));
		write_length(lv);
		alphabet.delete();
		repeat ($urandom_range(1, 3)) alphabet.insert(alphabet.size(), EW'($urandom));
		if ($urandom_range(1) == 0) begin
			for (k = 0; k < active_len; k++)
				load_slot(k, ($urandom_range(4) == 0) ? EW'($urandom) : text_elem());
		end else begin
			for (k = active_len - 1; k >= 0; k--)
				load_slot(k, ($urandom_range(4) == 0) ? EW'($urandom) : text_elem());
		end
		repeat ($urandom_range(2)) load_slot($urandom_range(DEPTH - 1), EW'($urandom));
		if (phase_no == 3 || $urandom_range(14) == 0) begin
			hold_asks++;
			send_text(60);
		end
		repeat ($urandom_range(1, 4)) send_text($urandom_range(1, active_len + 12));
	endtask

	initial begin
		int phase_no;
		int stop_at;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		item_ch.valid         = 1'b0;
		item_ch.kind          = KIND_PATTERN;
		item_ch.element       = '0;
		item_ch.pattern_index = '0;
		item_ch.first_of_text = 1'b0;
		item_ch.last_of_text  = 1'b0;
		burst_left            = 0;
		item_count            = 0;
		active_len            = 1;
		hold_asks             = 0;
		alphabet.insert(alphabet.size(), 16'h1234);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < DEPTH; k++) begin
			case (k)
				0: begin
					load_slot(k, 16'hFFFF);
				end
				1: begin
					load_slot(k, 16'h0000);
				end
				2: begin
					load_slot(k, 16'h8001);
				end
				default: begin
					load_slot(k, EW'($urandom));
				end
			endcase
		end

		write_length(0);
		put_text(16'hFFFF, 1'b1, 1'b0);
		put_text(16'h1234, 1'b0, 1'b0);
		put_text(16'hFFFF, 1'b0, 1'b1);
		write_length(3);
		put_text(16'hFFFF, 1'b1, 1'b0);
		put_text(16'h0000, 1'b0, 1'b1);
		put_text(16'h8001, 1'b0, 1'b0);
		put_text(16'h8001, 1'b1, 1'b1);
		put_text(16'hFFFF, 1'b1, 1'b0);
		put_text(16'h0000, 1'b0, 1'b0);
		load_slot(2, 16'h5A5A);
		put_text(16'h5A5A, 1'b0, 1'b1);
		write_length(63);
		put_text(16'hFFFF, 1'b1, 1'b1);

		phase_no = 0;
		stop_at  = item_count + RAND_ITEMS;
		while (item_count < stop_at) begin
			run_phase(phase_no);
			phase_no++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("** sliding_window_pattern_match_core: PASSED **");
		else
			$display("** sliding_window_pattern_match_core: FAILED **");
		$finish;
	end

endmodule
